// ===== rtl/eaptls_pkg.sv =====
// shared types and constants for the eap-tls fragment reassembler
// no dependencies; imported by every rtl module of the block
package eaptls_pkg;

  // receive buffer size in bytes and derived widths
  localparam int BufBytes = 4096;
  localparam int AddrW    = $clog2(BufBytes);
  localparam int CntW     = 13;
  localparam int LenBytes = 4;
  localparam int PosW     = 3;
  localparam int PosMax   = 5;

  // flags byte bit positions
  localparam int FlagLBit = 7;
  localparam int FlagMBit = 6;
  localparam int FlagSBit = 5;

  // result status codes
  localparam logic [1:0] StAccept = 2'd0;
  localparam logic [1:0] StStart  = 2'd1;
  localparam logic [1:0] StReject = 2'd2;

  // command codes
  localparam logic CmdFrag = 1'b0;
  localparam logic CmdRead = 1'b1;

  typedef struct packed {
    logic        command;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [11:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  frag_flags;
    logic        message_complete;
    logic [12:0] bytes_held;
    logic [12:0] message_total;
    logic [7:0]  read_data;
  } out_item_t;

  // byte class decided by the front end
  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_FLAGS   = 3'd1,
    OP_LEN     = 3'd2,
    OP_PAYLOAD = 3'd3,
    OP_SKIP    = 3'd4
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [11:0] read_index;
    logic [7:0]  flags;
    logic        len_final;
    logic        short_len;
  } op_t;

endpackage

// ===== rtl/eap_tls_fragment_reassembler.sv =====
// eap-tls receive fragment reassembler, top level
// out_valid_o rises once the input transfer has passed the queue, then the result register
// throughput: one item per cycle while the output is not stalled; the back end retires one
//   queued op a cycle and writes or reads the 4096-byte buffer through a single port
// reset: asynchronous active-low rst_ni clears position, flags, counts and handshake state;
//   buffer contents are not cleared and there is no clearing pass
module eap_tls_fragment_reassembler (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  eaptls_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output eaptls_pkg::out_item_t out_data_o
);
  import eaptls_pkg::*;

  // classified ops from the front end into the queue
  op_t  push_op;
  logic push;
  logic q_full;

  // queue head toward the back end
  op_t  head_op;
  logic head_valid;
  logic head_pop;

  // front end: byte position and flags tracking, byte classification
  eaptls_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  // short queue so a stalled output does not stop input transfers at once
  eaptls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .valid_o (head_valid),
    .op_o    (head_op),
    .pop_i   (head_pop)
  );

  // back end: counts, total lock, buffer writes and reads, result register
  eaptls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_valid),
    .op_i        (head_op),
    .pop_o       (head_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/eaptls_front.sv =====
// front end: accepts input items, tracks fragment byte position and flags,
// and classifies each byte into an op_t; uses eaptls_pkg
module eaptls_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  eaptls_pkg::in_item_t in_data_i,
  input  logic                 full_i,
  output logic                 push_o,
  output eaptls_pkg::op_t      op_o
);
  import eaptls_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      flags_q, flags_d;
  logic [7:0]      flags_eff;
  logic            accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_comb begin
    flags_eff = (pos_q == '0) ? in_data_i.data_byte : flags_q;
    op_o.data_byte  = in_data_i.data_byte;
    op_o.last_byte  = in_data_i.last_byte;
    op_o.read_index = in_data_i.read_index;
    op_o.flags      = flags_eff;
    op_o.len_final  = (pos_q == PosW'(LenBytes));
    op_o.short_len  = flags_eff[FlagLBit] && (pos_q < PosW'(LenBytes));
    if (in_data_i.command == CmdRead) begin
      op_o.kind = OP_READ;
    end else if (pos_q == '0) begin
      op_o.kind = OP_FLAGS;
    end else if (flags_eff[FlagSBit]) begin
      op_o.kind = OP_SKIP;
    end else if (flags_eff[FlagLBit] && (pos_q <= PosW'(LenBytes))) begin
      op_o.kind = OP_LEN;
    end else begin
      op_o.kind = OP_PAYLOAD;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    flags_d = flags_q;
    if (accept && in_data_i.command == CmdFrag) begin
      flags_d = flags_eff;
      if (in_data_i.last_byte) begin
        pos_d = '0;
      end else if (pos_q < PosW'(PosMax)) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      flags_q <= '0;
    end else begin
      pos_q   <= pos_d;
      flags_q <= flags_d;
    end
  end

endmodule

// ===== rtl/eaptls_queue.sv =====
// two-entry queue of classified ops between front and back end
// uses eaptls_pkg for op_t
module eaptls_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  eaptls_pkg::op_t op_i,
  output logic            full_o,
  output logic            valid_o,
  output eaptls_pkg::op_t op_o,
  input  logic            pop_i
);
  import eaptls_pkg::*;

  op_t        entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/eaptls_back.sv =====
// back end: message state, payload buffer and the result register
// uses eaptls_pkg; fed by eaptls_queue
module eaptls_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  eaptls_pkg::op_t       op_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output eaptls_pkg::out_item_t out_data_o
);
  import eaptls_pkg::*;

  logic [7:0]      store_q [BufBytes];

  logic [CntW-1:0] committed_q, committed_d;
  logic [CntW-1:0] locked_q, locked_d;
  logic            complete_q, complete_d;
  logic [31:0]     shift_q, shift_d;
  logic [CntW-1:0] pending_q, pending_d;
  logic            err_q, err_d;

  logic            res_valid_q;
  out_item_t       res_q, res_d;
  logic            rd_ok_q, rd_ok_d;
  logic [7:0]      rdata_q;

  logic            gives_result, exec, res_load;
  logic            wr_en, rd_en;
  logic [CntW:0]   at, sum;
  logic [1:0]      status;

  assign gives_result = (op_i.kind == OP_READ) || op_i.last_byte;
  assign exec  = valid_i && (!gives_result || !res_valid_q || out_ready_i);
  assign pop_o = exec;

  assign at = {1'b0, committed_q} + {1'b0, pending_q};

  always_comb begin
    committed_d = committed_q;
    locked_d    = locked_q;
    complete_d  = complete_q;
    shift_d     = shift_q;
    pending_d   = pending_q;
    err_d       = err_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    res_load    = 1'b0;
    rd_ok_d     = 1'b0;
    res_d       = '0;
    sum         = '0;
    status      = StAccept;
    if (exec) begin
      unique case (op_i.kind)
        OP_READ: begin
          rd_en    = 1'b1;
          rd_ok_d  = ({1'b0, op_i.read_index} < 13'(BufBytes));
        end
        OP_FLAGS: begin
          // a new fragment after a finished message starts over
          if (complete_q) begin
            committed_d = '0;
            locked_d    = '0;
            complete_d  = 1'b0;
          end
        end
        OP_LEN: begin
          shift_d = {shift_q[23:0], op_i.data_byte};
          if (op_i.len_final && locked_q == '0 && !err_q) begin
            if (shift_d > 32'(BufBytes) || shift_d < 32'(committed_q)) begin
              err_d = 1'b1;
            end else begin
              locked_d = shift_d[CntW-1:0];
            end
          end
        end
        OP_PAYLOAD: begin
          if (!err_q) begin
            wr_en = (at < (CntW+1)'(BufBytes));
            if (pending_q <= CntW'(BufBytes)) begin
              pending_d = pending_q + 1'b1;
            end
          end
        end
        OP_SKIP: begin
        end
        default: begin
        end
      endcase

      if (op_i.kind == OP_READ) begin
        res_load = 1'b1;
      end else if (op_i.last_byte) begin
        res_load = 1'b1;
        sum = {1'b0, committed_d} + {1'b0, pending_d};
        if (op_i.flags[FlagSBit]) begin
          status = StStart;
        end else if (op_i.short_len || err_d) begin
          status = StReject;
        end else begin
          if (pending_d != '0) begin
            if (sum > (CntW+1)'(BufBytes) ||
                (locked_d != '0 && sum > {1'b0, locked_d})) begin
              status = StReject;
            end else begin
              committed_d = sum[CntW-1:0];
            end
          end
          if (status == StAccept && !op_i.flags[FlagMBit]) begin
            complete_d = 1'b1;
            if (locked_d == '0) locked_d = committed_d;
          end
        end
        res_d.frag_flags = op_i.flags;
        shift_d   = '0;
        pending_d = '0;
        err_d     = 1'b0;
      end
      res_d.status           = status;
      res_d.message_complete = complete_d;
      res_d.bytes_held       = committed_d;
      res_d.message_total    = locked_d;
    end
  end

  // payload buffer, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[at[AddrW-1:0]] <= op_i.data_byte;
    end
    if (rd_en) begin
      rdata_q <= store_q[op_i.read_index[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q   <= res_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q <= '0;
      locked_q    <= '0;
      complete_q  <= 1'b0;
      shift_q     <= '0;
      pending_q   <= '0;
      err_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      committed_q <= committed_d;
      locked_q    <= locked_d;
      complete_q  <= complete_d;
      shift_q     <= shift_d;
      pending_q   <= pending_d;
      err_q       <= err_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    out_data_o           = res_q;
    out_data_o.read_data = rd_ok_q ? rdata_q : 8'd0;
  end
  assign out_valid_o = res_valid_q;

`ifndef NO_ASSERTIONS
  a_committed_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    committed_q <= CntW'(BufBytes))
    else $error("committed count beyond buffer");
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CntW'(BufBytes + 1))
    else $error("pending count beyond saturation");
  a_locked_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q <= CntW'(BufBytes))
    else $error("locked total beyond buffer");
  a_complete_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete_q |-> committed_q <= locked_q)
    else $error("complete message exceeds its total");
`endif

endmodule
